// ----- sv/cpod_pkg.sv -----
// ============================================================================
// cpod_pkg
// Shared types and constants for the circle pair overlap detector.
// ============================================================================
`default_nettype none

package cpod_pkg;

  localparam int X_W   = 16;  // center coordinate width, signed
  localparam int R_W   = 15;  // radius width, unsigned
  localparam int IDX_W = 7;   // circle number width on the result channel
  localparam int D_W   = 16;  // magnitude of a coordinate difference or radius sum
  localparam int SQ_W  = 32;  // square of a D_W value

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic        [R_W-1:0] r;
  } circle_t;

  // Status of the compare pipeline as seen by the sequencer
  typedef struct packed {
    logic             busy;       // any stage holds an item
    logic             res_valid;  // last stage holds a finished compare
    logic             res_hit;    // that compare found an overlap
    logic [IDX_W-1:0] res_idx;    // store entry of that compare
  } cmp_stat_t;

endpackage

`default_nettype wire

// ----- sv/cpod_in_if.sv -----
// ============================================================================
// cpod_in_if
// Input channel: one add or clear command with a circle.
// ============================================================================
`default_nettype none

interface cpod_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [cpod_pkg::X_W-1:0]    x_center;
  logic signed [cpod_pkg::X_W-1:0]    y_center;
  logic        [cpod_pkg::R_W-1:0]    radius;

  modport source (output valid, cmd, x_center, y_center, radius, input ready);
  modport sink   (input valid, cmd, x_center, y_center, radius, output ready);
endinterface

`default_nettype wire

// ----- sv/cpod_out_if.sv -----
// ============================================================================
// cpod_out_if
// Result channel: one overlapping pair or one rejection.
// ============================================================================
`default_nettype none

interface cpod_out_if;
  logic                         valid;
  logic                         ready;
  logic [cpod_pkg::IDX_W-1:0]   older_index;
  logic [cpod_pkg::IDX_W-1:0]   newer_index;
  logic                         rejected;
  logic                         last;

  modport source (output valid, older_index, newer_index, rejected, last, input ready);
  modport sink   (input valid, older_index, newer_index, rejected, last, output ready);
endinterface

`default_nettype wire

// ----- sv/cpod_store.sv -----
// ============================================================================
// cpod_store
// Circle memory: one write port, one registered read port.
// ============================================================================
`default_nettype none

module cpod_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire cpod_pkg::circle_t wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output cpod_pkg::circle_t      rdata
);

  cpod_pkg::circle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpod_cmp.sv -----
// ============================================================================
// cpod_cmp
// Overlap compare pipeline: difference, square, sum and compare.
// ============================================================================
`default_nettype none

module cpod_cmp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        issue,
  input  wire logic [cpod_pkg::IDX_W-1:0]  issue_idx,
  input  wire cpod_pkg::circle_t           old_c,
  input  wire cpod_pkg::circle_t           new_c,
  output cpod_pkg::cmp_stat_t              stat
);

  localparam int DW = cpod_pkg::D_W;
  localparam int SW = cpod_pkg::SQ_W;

  logic                        v1, v2, v3, v4;
  logic [cpod_pkg::IDX_W-1:0]  idx1, idx2, idx3, idx4;
  logic [DW-1:0]               ax, ay, rs;
  logic [SW-1:0]               sx, sy, rr;
  logic                        hit4;

  logic [DW:0]   dx, dy;
  logic [DW:0]   ndx, ndy;
  logic [DW-1:0] rsum;

  always_comb begin
    dx   = {old_c.x[cpod_pkg::X_W-1], old_c.x} - {new_c.x[cpod_pkg::X_W-1], new_c.x};
    dy   = {old_c.y[cpod_pkg::X_W-1], old_c.y} - {new_c.y[cpod_pkg::X_W-1], new_c.y};
    ndx  = (~dx) + 1'b1;
    ndy  = (~dy) + 1'b1;
    rsum = {1'b0, old_c.r} + {1'b0, new_c.r};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= issue_idx;
      // stage 2: magnitudes of the differences and the radius sum
      idx2 <= idx1;
      ax   <= dx[DW] ? ndx[DW-1:0] : dx[DW-1:0];
      ay   <= dy[DW] ? ndy[DW-1:0] : dy[DW-1:0];
      rs   <= rsum;
      // stage 3: squares
      idx3 <= idx2;
      sx   <= ax * ax;
      sy   <= ay * ay;
      rr   <= rs * rs;
      // stage 4: touching counts as overlap
      idx4 <= idx3;
      hit4 <= ({1'b0, rr} >= ({1'b0, sx} + {1'b0, sy}));
    end
  end

  always_comb begin
    stat.busy      = v1 | v2 | v3 | v4;
    stat.res_valid = v4;
    stat.res_hit   = hit4;
    stat.res_idx   = idx4;
  end

endmodule

`default_nettype wire

// ----- sv/circle_pair_overlap_detector_core.sv -----
// ============================================================================
// circle_pair_overlap_detector_core
// Stores circles and reports each earlier circle that overlaps a new one.
// ============================================================================
// Results: each hit waits in a hold register until the next hit or the end of
//   the scan, and a new command is taken only once the scan has ended. The scan
//   does one memory read per cycle while the output is not stalled; an output
//   stall holds the whole compare pipeline. Clear and rejected adds start no
//   scan. Reset clears count and control, not the memory.
`default_nettype none

module circle_pair_overlap_detector_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cpod_in_if.sink     circ_in,
  cpod_out_if.source  hit_out
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = cpod_pkg::IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count;      // number of stored circles
  logic [CW-1:0]       slot;       // entry of the circle being checked
  logic [CW-1:0]       rd_idx;     // next entry to read
  cpod_pkg::circle_t   new_c;
  logic                hold_valid; // newest hit, kept until we know if it is last
  logic [IDX_W-1:0]    hold_idx;

  logic                out_valid;
  logic [IDX_W-1:0]    out_older, out_newer;
  logic                out_rej, out_last;

  logic                out_free, adv, issue, accept, scan_done;
  logic                out_load;
  logic [IDX_W-1:0]    load_older, load_newer;
  logic                load_rej, load_last;
  logic                res_hit;
  logic                is_full;

  cpod_pkg::circle_t   in_c, rd_c;
  cpod_pkg::cmp_stat_t stat;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid || hit_out.ready;
  // Whole compare pipeline moves only when a hit could be written out.
  assign adv      = out_free;
  assign issue    = (state == ST_SCAN) && (rd_idx < slot);
  assign is_full  = (count == CW'(CAPACITY));

  assign circ_in.ready = (state == ST_IDLE) && out_free;
  assign accept        = circ_in.valid && circ_in.ready;

  assign res_hit   = adv && stat.res_valid && stat.res_hit;
  assign scan_done = (state == ST_SCAN) && !issue && !stat.busy;

  always_comb begin
    in_c.x = circ_in.x_center;
    in_c.y = circ_in.y_center;
    in_c.r = circ_in.radius;
  end

  cpod_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept && (circ_in.cmd == cpod_pkg::CMD_ADD) && !is_full),
    .waddr (count[AW-1:0]),
    .wdata (in_c),
    .re    (adv && issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_c)
  );

  cpod_cmp u_cmp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .issue     (issue),
    .issue_idx (IDX_W'(rd_idx)),
    .old_c     (rd_c),
    .new_c     (new_c),
    .stat      (stat)
  );

  // Pick what goes into the output register this cycle.
  always_comb begin
    out_load   = 1'b0;
    load_older = hold_idx + 1'b1;
    load_newer = IDX_W'(slot) + 1'b1;
    load_rej   = 1'b0;
    load_last  = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (circ_in.cmd == cpod_pkg::CMD_ADD)) begin
          if (is_full) begin
            // reject: one result with zero indices
            out_load   = 1'b1;
            load_older = '0;
            load_newer = '0;
            load_rej   = 1'b1;
            load_last  = 1'b1;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (res_hit && hold_valid) begin
          // a newer hit arrived, so the held one is not last
          out_load = 1'b1;
        end else if (scan_done) begin
          if (!hold_valid) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load   = 1'b1;
            load_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_idx     <= '0;
      slot       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (circ_in.cmd == cpod_pkg::CMD_CLEAR) begin
          count <= '0;
        end else if (!is_full) begin
          slot   <= count;
          count  <= count + 1'b1;
          rd_idx <= '0;
        end
      end
      if (adv && issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      // hold the newest hit; drop it once it went out as last
      if (res_hit) begin
        hold_valid <= 1'b1;
      end else if (out_load && load_last && !load_rej) begin
        hold_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (hit_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      new_c <= in_c;
    end
    if (res_hit) begin
      hold_idx <= stat.res_idx;
    end
    if (out_load) begin
      out_older <= load_older;
      out_newer <= load_newer;
      out_rej   <= load_rej;
      out_last  <= load_last;
    end
  end

  assign hit_out.valid       = out_valid;
  assign hit_out.older_index = out_older;
  assign hit_out.newer_index = out_newer;
  assign hit_out.rejected    = out_rej;
  assign hit_out.last        = out_last;

endmodule

`default_nettype wire

// ----- sv/cpod_checker.sv -----
// ============================================================================
// cpod_checker
// Port-level checks on the result channel of the overlap detector.
// ============================================================================
`default_nettype none

module cpod_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_cmd,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cpod_pkg::IDX_W-1:0]  older_index,
  input wire logic [cpod_pkg::IDX_W-1:0]  newer_index,
  input wire logic                        rejected,
  input wire logic                        last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A rejection is a single result with zero indices.
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> last && (older_index == '0) && (newer_index == '0))
    else $error("malformed rejection");

  // A pair names an earlier circle and a nonzero newer circle.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rejected |-> (newer_index != '0) && (older_index != '0)
                               && (older_index < newer_index))
    else $error("pair indices out of order");

  // A clear item causes no result.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == cpod_pkg::CMD_CLEAR) |=> !$rose(out_valid))
    else $error("result after clear");

endmodule

bind circle_pair_overlap_detector_core cpod_checker u_cpod_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (circ_in.valid),
  .in_ready    (circ_in.ready),
  .in_cmd      (circ_in.cmd),
  .out_valid   (hit_out.valid),
  .out_ready   (hit_out.ready),
  .older_index (hit_out.older_index),
  .newer_index (hit_out.newer_index),
  .rejected    (hit_out.rejected),
  .last        (hit_out.last)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the circle pair overlap detector. Adds circles,
// clears the store and fills it past capacity, while a local model of the
// circle store predicts every overlap pair and every rejection. Results are
// compared in order, field by field, under three sender/receiver idle mixes.
// ============================================================================

module tb_top;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  // The slowest add scans every stored circle; wait out that scan
  localparam int SETTLE_CYCLES = CAPACITY + 20;

  typedef struct packed {
    logic [cpod_pkg::IDX_W-1:0] older;
    logic [cpod_pkg::IDX_W-1:0] newer;
    logic                       rejected;
    logic                       last;
  } overlap_rec_t;

  logic clk;
  logic rst;

  cpod_in_if  circ_in_bus ();
  cpod_out_if hit_out_bus ();

  circle_pair_overlap_detector_core #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .circ_in (circ_in_bus),
    .hit_out (hit_out_bus)
  );

  // Local copy of the circle store
  logic signed [cpod_pkg::X_W-1:0] stored_x [CAPACITY];
  logic signed [cpod_pkg::X_W-1:0] stored_y [CAPACITY];
  logic        [cpod_pkg::R_W-1:0] stored_r [CAPACITY];
  int                              stored_count;

  overlap_rec_t pending_overlaps [$];

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int cluster_x;
  int cluster_y;

  // --------------------------------------------------------------------------
  // Clock, cycle limit, receiver back-pressure
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: cycle limit of %0d reached", CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Drop ready at random, at the rate of the current idle mix
  always @(posedge clk) begin
    hit_out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Overlap prediction
  // --------------------------------------------------------------------------
  // Store the circle, then test it against every older one, oldest first.
  // Touching counts as overlap: (r1+r2)^2 >= dx^2 + dy^2, in 64-bit math.
  task automatic predict_overlaps(input logic cmd,
                                  input logic signed [cpod_pkg::X_W-1:0] x,
                                  input logic signed [cpod_pkg::X_W-1:0] y,
                                  input logic [cpod_pkg::R_W-1:0] r);
    int           hits [$];
    int           slot;
    longint       dx;
    longint       dy;
    longint       rsum;
    overlap_rec_t rec;
    if (cmd == cpod_pkg::CMD_CLEAR) begin
      stored_count = 0;
      return;
    end
    // Full store: one rejection, nothing stored
    if (stored_count >= CAPACITY) begin
      rec.older    = '0;
      rec.newer    = '0;
      rec.rejected = 1'b1;
      rec.last     = 1'b1;
      pending_overlaps = {pending_overlaps, rec};
      return;
    end
    slot = stored_count;
    stored_x[slot] = x;
    stored_y[slot] = y;
    stored_r[slot] = r;
    stored_count   = slot + 1;
    for (int i = 0; i < slot; i++) begin
      dx   = longint'(x) - longint'(stored_x[i]);
      dy   = longint'(y) - longint'(stored_y[i]);
      rsum = longint'(r) + longint'(stored_r[i]);
      if (rsum * rsum >= dx * dx + dy * dy) hits = {hits, i};
    end
    foreach (hits[k]) begin
      rec.older    = cpod_pkg::IDX_W'(hits[k] + 1);
      rec.newer    = cpod_pkg::IDX_W'(slot + 1);
      rec.rejected = 1'b0;
      rec.last     = (k == hits.size() - 1);
      pending_overlaps = {pending_overlaps, rec};
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR: %0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result checking: pair each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    overlap_rec_t want;
    if (!rst && hit_out_bus.valid && hit_out_bus.ready) begin
      if (pending_overlaps.size() == 0) begin
        report_mismatch($sformatf("unexpected result older=%0d newer=%0d rej=%0b last=%0b",
                                  hit_out_bus.older_index, hit_out_bus.newer_index,
                                  hit_out_bus.rejected, hit_out_bus.last));
      end else begin
        want = pending_overlaps.pop_front();
        if (hit_out_bus.older_index !== want.older)
          report_mismatch($sformatf("older_index %0d, expected %0d",
                                    hit_out_bus.older_index, want.older));
        if (hit_out_bus.newer_index !== want.newer)
          report_mismatch($sformatf("newer_index %0d, expected %0d",
                                    hit_out_bus.newer_index, want.newer));
        if (hit_out_bus.rejected !== want.rejected)
          report_mismatch($sformatf("rejected %0b, expected %0b",
                                    hit_out_bus.rejected, want.rejected));
        if (hit_out_bus.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (older %0d newer %0d)",
                                    hit_out_bus.last, want.last, want.older, want.newer));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Called just after the clock rises. Valid stays high between back-to-back
  // items; it is only lowered in a step where it is not raised again.
  task automatic send_item(input logic cmd, input logic signed [cpod_pkg::X_W-1:0] x,
                           input logic signed [cpod_pkg::X_W-1:0] y,
                           input logic [cpod_pkg::R_W-1:0] r);
    if ($urandom_range(99) < send_idle_pct) begin
      circ_in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    circ_in_bus.valid    <= 1'b1;
    circ_in_bus.cmd      <= cmd;
    circ_in_bus.x_center <= x;
    circ_in_bus.y_center <= y;
    circ_in_bus.radius   <= r;
    do @(posedge clk); while (!circ_in_bus.ready);
    predict_overlaps(cmd, x, y, r);
  endtask

  task automatic add_circle(input int x, input int y, input int r);
    send_item(cpod_pkg::CMD_ADD, cpod_pkg::X_W'(x), cpod_pkg::X_W'(y), cpod_pkg::R_W'(r));
  endtask

  // Clear with random payload; the payload must not matter
  task automatic clear_store();
    send_item(cpod_pkg::CMD_CLEAR, cpod_pkg::X_W'($urandom()), cpod_pkg::X_W'($urandom()),
              cpod_pkg::R_W'($urandom()));
  endtask

  task automatic pick_cluster();
    cluster_x = int'($urandom_range(50000)) - 25000;
    cluster_y = int'($urandom_range(50000)) - 25000;
  endtask

  function automatic int near_cluster(input int c);
    return c + int'($urandom_range(3000)) - 1500;
  endfunction

  // Hold the sender until every expected result is in, then let any
  // silent add or clear finish
  task automatic drain_results();
    circ_in_bus.valid <= 1'b0;
    while (pending_overlaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, first circle, touching circles, points, no-overlap adds,
  // and numbering restarting after a clear
  task automatic test_directed();
    clear_store();                           // clear on an empty store
    add_circle(0, 0, 3);                     // first circle, no result
    add_circle(3, 4, 2);                     // touches circle 1 exactly
    add_circle(3, 4, 1);                     // misses 1 by one, overlaps 2
    add_circle(100, 100, 0);                 // point, no overlap
    add_circle(100, 100, 0);                 // coincident points overlap
    add_circle(101, 100, 0);                 // points one apart do not
    add_circle(-32768, -32768, 0);
    add_circle(32767, 32767, 32767);
    add_circle(-32768, 32767, 32767);        // full-span gap, misses by one
    add_circle(32767, -32768, 32767);
    add_circle(0, 0, 32767);
    add_circle(-32768, -32768, 32767);       // largest radius at the corner
    add_circle(32767, 32767, 0);
    clear_store();
    add_circle(-1, -1, 1);                   // numbering restarts at 1
    add_circle(1, 1, 1);
    add_circle(-32768, 32767, 16383);
  endtask

  // Fill the store, make the last stored circle hit all earlier ones, then
  // add past capacity
  task automatic test_full_store();
    clear_store();
    pick_cluster();
    for (int i = 0; i < CAPACITY - 1; i++)
      add_circle(near_cluster(cluster_x), near_cluster(cluster_y),
                 int'($urandom_range(400)));
    add_circle(cluster_x, cluster_y, 32767);
    add_circle(int'($urandom_range(65535)) - 32768, 0, 5);
    add_circle(cluster_x, cluster_y, 0);
    clear_store();
    add_circle(cluster_x, cluster_y, 7);
    add_circle(cluster_x, cluster_y, 0);
  endtask

  // Mostly clustered circles so overlaps are common; some fully random
  // fields, some huge circles, and an occasional clear
  task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct);
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    pick_cluster();
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        clear_store();
        pick_cluster();
      end else if (pick < 14) begin
        send_item(cpod_pkg::CMD_ADD, cpod_pkg::X_W'($urandom()),
                  cpod_pkg::X_W'($urandom()), cpod_pkg::R_W'($urandom()));
      end else if (pick < 19) begin
        add_circle(near_cluster(cluster_x), near_cluster(cluster_y),
                   int'($urandom_range(32767, 20000)));
      end else begin
        add_circle(near_cluster(cluster_x), near_cluster(cluster_y),
                   int'($urandom_range(800)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    stored_count   = 0;
    send_idle_pct  = 8;
    recv_idle_pct  = 75;
    cluster_x      = 0;
    cluster_y      = 0;

    rst                  <= 1'b1;
    circ_in_bus.valid    <= 1'b0;
    circ_in_bus.cmd      <= cpod_pkg::CMD_ADD;
    circ_in_bus.x_center <= '0;
    circ_in_bus.y_center <= '0;
    circ_in_bus.radius   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    drain_results();
    test_full_store();
    drain_results();
    test_random_mix(60, 8, 75);
    drain_results();
    test_random_mix(60, 75, 8);
    drain_results();
    test_random_mix(60, 0, 0);
    drain_results();

    if (mismatch_count == 0 && pending_overlaps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
